// ===== src/dmc_pkg.sv =====
package dmc_pkg;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_TUNE  = 2'd2,
        MODE_FAULT = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_CLICK = 3'd1,
        CMD_LONG  = 3'd2,
        CMD_START = 3'd3,
        CMD_STOP  = 3'd4,
        CMD_SET   = 3'd5,
        CMD_TUNE  = 3'd6,
        CMD_CLEAR = 3'd7
    } cmd_t;

    localparam int LIMIT_WIDTH = 15;
    localparam int DRIVE_WIDTH = 16;
    localparam int LEN_WIDTH   = 8;

    localparam logic [LIMIT_WIDTH-1:0]        LIMIT_RESET    = 15'd1000;
    localparam logic signed [DRIVE_WIDTH-1:0] SPEED_RESET    = 16'sd300;
    localparam logic [LEN_WIDTH-1:0]          MIN_SET_LENGTH = 8'd4;

endpackage

// ===== src/dmc_if.sv =====
interface dmc_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    command;
    logic                          estop_in;
    logic signed [SAMPLE_WIDTH-1:0] line_left;
    logic signed [SAMPLE_WIDTH-1:0] line_right;
    logic signed [SAMPLE_WIDTH-1:0] speed_meas;
    logic signed [15:0]            target_speed_in;
    logic signed [15:0]            target_turn_in;
    logic [7:0]                    payload_length;

    modport source (
        output valid, command, estop_in, line_left, line_right,
               speed_meas, target_speed_in, target_turn_in, payload_length,
        input  ready
    );

    modport sink (
        input  valid, command, estop_in, line_left, line_right,
               speed_meas, target_speed_in, target_turn_in, payload_length,
        output ready
    );
endinterface

interface dmc_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [15:0] left_drive;
    logic signed [15:0] right_drive;
    logic               buzzer;

    modport source (
        output valid, mode, left_drive, right_drive, buzzer,
        input  ready
    );

    modport sink (
        input  valid, mode, left_drive, right_drive, buzzer,
        output ready
    );
endinterface

// ===== src/drive_mode_controller_top.sv =====
// Drive mode controller (stop, run, tune, fault). One result per accepted
// event, carrying the mode and the held wheel drives and buzzer after that
// event. An event is captured in an input register, then processed by the
// mode logic and the drive mixer (adders plus a clamp against limit_reg)
// on its way into the result register; the updated state is the result,
// and one event per cycle is sustained while the result side keeps up.
// The result register holds while the sink stalls and the input register
// takes one more event behind it.
module drive_mode_controller_top #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [dmc_pkg::LIMIT_WIDTH-1:0]   cfg_wr_data,
    dmc_in_if.sink                            cmd_ch,
    dmc_out_if.source                         res_ch
);

    localparam int CW = ((SAMPLE_WIDTH > dmc_pkg::DRIVE_WIDTH) ?
                         SAMPLE_WIDTH : dmc_pkg::DRIVE_WIDTH) + 3;

    logic [dmc_pkg::LIMIT_WIDTH-1:0] limit_reg;

    logic                           s1_valid_reg;
    dmc_pkg::cmd_t                  s1_cmd_reg;
    logic                           s1_estop_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sl_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_sr_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_fb_reg;
    logic signed [15:0]             s1_tspd_reg;
    logic signed [15:0]             s1_tturn_reg;
    logic [7:0]                     s1_len_reg;

    logic                           out_valid_reg;
    dmc_pkg::mode_t                 mode_reg, mode_next;
    logic signed [15:0]             speed_reg, speed_next;
    logic signed [15:0]             turn_reg, turn_next;
    logic signed [15:0]             left_reg, left_next;
    logic signed [15:0]             right_reg, right_next;
    logic                           buzzer_reg, buzzer_next;

    logic                           advance;
    logic                           enter_en;
    dmc_pkg::mode_t                 enter_mode;
    dmc_pkg::mode_t                 tick_mode;
    logic signed [CW-1:0]           drive_w;
    logic signed [CW-1:0]           line_w;
    logic signed [CW-1:0]           left_w;
    logic signed [CW-1:0]           right_w;

    function automatic logic signed [15:0] clamp_lim(
        input logic signed [CW-1:0]           v,
        input logic [dmc_pkg::LIMIT_WIDTH-1:0] lim
    );
        logic signed [CW-1:0] pos;
        logic signed [CW-1:0] neg;
        pos = $signed({{(CW - dmc_pkg::LIMIT_WIDTH){1'b0}}, lim});
        neg = -pos;
        if (v < neg)
        begin
            return neg[15:0];
        end
        if (v > pos)
        begin
            return pos[15:0];
        end
        return v[15:0];
    endfunction

    assign advance      = s1_valid_reg && (!out_valid_reg || res_ch.ready);
    assign cmd_ch.ready = !s1_valid_reg || advance;

    assign res_ch.valid       = out_valid_reg;
    assign res_ch.mode        = mode_reg;
    assign res_ch.left_drive  = left_reg;
    assign res_ch.right_drive = right_reg;
    assign res_ch.buzzer      = buzzer_reg;

    always_comb
    begin
        drive_w = CW'(s1_fb_reg);
        drive_w = CW'(speed_reg) - drive_w;
        line_w  = CW'(s1_sl_reg) - CW'(s1_sr_reg);
        left_w  = drive_w - CW'(turn_reg) - line_w;
        right_w = drive_w + CW'(turn_reg) + line_w;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        speed_next  = speed_reg;
        turn_next   = turn_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        buzzer_next = buzzer_reg;
        enter_en    = 1'b0;
        enter_mode  = mode_reg;
        tick_mode   = s1_estop_reg ? dmc_pkg::MODE_FAULT : mode_reg;

        unique case (s1_cmd_reg)
            dmc_pkg::CMD_TICK:
            begin
                mode_next = tick_mode;
                if (tick_mode == dmc_pkg::MODE_RUN)
                begin
                    left_next   = clamp_lim(left_w, limit_reg);
                    right_next  = clamp_lim(right_w, limit_reg);
                    buzzer_next = 1'b0;
                end
                else
                begin
                    left_next   = '0;
                    right_next  = '0;
                    buzzer_next = (tick_mode == dmc_pkg::MODE_FAULT);
                end
            end
            dmc_pkg::CMD_CLICK:
            begin
                if (mode_reg == dmc_pkg::MODE_STOP)
                begin
                    enter_en   = 1'b1;
                    enter_mode = dmc_pkg::MODE_RUN;
                end
                else if (mode_reg != dmc_pkg::MODE_FAULT)
                begin
                    enter_en   = 1'b1;
                    enter_mode = dmc_pkg::MODE_STOP;
                end
            end
            dmc_pkg::CMD_LONG:
            begin
                enter_en   = (mode_reg != dmc_pkg::MODE_FAULT);
                enter_mode = dmc_pkg::MODE_TUNE;
            end
            dmc_pkg::CMD_START:
            begin
                enter_en   = 1'b1;
                enter_mode = dmc_pkg::MODE_RUN;
            end
            dmc_pkg::CMD_STOP:
            begin
                enter_en   = 1'b1;
                enter_mode = dmc_pkg::MODE_STOP;
            end
            dmc_pkg::CMD_SET:
            begin
                if (s1_len_reg >= dmc_pkg::MIN_SET_LENGTH)
                begin
                    speed_next = clamp_lim(CW'(s1_tspd_reg), limit_reg);
                    turn_next  = clamp_lim(CW'(s1_tturn_reg), limit_reg);
                end
            end
            dmc_pkg::CMD_TUNE:
            begin
                enter_en   = 1'b1;
                enter_mode = dmc_pkg::MODE_TUNE;
            end
            dmc_pkg::CMD_CLEAR:
            begin
                enter_en   = (mode_reg == dmc_pkg::MODE_FAULT);
                enter_mode = dmc_pkg::MODE_STOP;
            end
            default:
            begin
                enter_en = 1'b0;
            end
        endcase

        if (enter_en)
        begin
            mode_next   = enter_mode;
            buzzer_next = (enter_mode == dmc_pkg::MODE_FAULT);
            if (enter_mode != dmc_pkg::MODE_RUN)
            begin
                left_next  = '0;
                right_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= dmc_pkg::LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_ch.ready)
        begin
            s1_valid_reg <= cmd_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            s1_cmd_reg   <= dmc_pkg::cmd_t'(cmd_ch.command);
            s1_estop_reg <= cmd_ch.estop_in;
            s1_sl_reg    <= cmd_ch.line_left;
            s1_sr_reg    <= cmd_ch.line_right;
            s1_fb_reg    <= cmd_ch.speed_meas;
            s1_tspd_reg  <= cmd_ch.target_speed_in;
            s1_tturn_reg <= cmd_ch.target_turn_in;
            s1_len_reg   <= cmd_ch.payload_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= dmc_pkg::MODE_STOP;
            speed_reg     <= dmc_pkg::SPEED_RESET;
            turn_reg      <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            buzzer_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                speed_reg     <= speed_next;
                turn_reg      <= turn_next;
                left_reg      <= left_next;
                right_reg     <= right_next;
                buzzer_reg    <= buzzer_next;
            end
            else if (res_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/dmc_checker.sv =====
module dmc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  mode,
    input logic [15:0] left_drive,
    input logic [15:0] right_drive,
    input logic        buzzer
);

    // stalled result holds its mode and drives
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mode) &&
        $stable(left_drive) && $stable(right_drive))
        else $error("result changed while stalled");

    a_buzzer_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (buzzer == (mode == dmc_pkg::MODE_FAULT)))
        else $error("buzzer does not follow fault mode");

    a_idle_drives: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (mode != dmc_pkg::MODE_RUN) |->
        (left_drive == 16'h0000) && (right_drive == 16'h0000))
        else $error("drives nonzero outside run");

    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_drive != 16'h8000) && (right_drive != 16'h8000))
        else $error("drive outside symmetric range");

endmodule

bind drive_mode_controller_top dmc_checker u_dmc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (res_ch.valid),
    .out_ready   (res_ch.ready),
    .mode        (res_ch.mode),
    .left_drive  (res_ch.left_drive),
    .right_drive (res_ch.right_drive),
    .buzzer      (res_ch.buzzer)
);
